### hw/rtl/smpq_pkg.sv
// Package for the sorted minimum priority queue.
// Holds action codes, the cell control struct and shared constants.
// Depends on nothing.
package smpq_pkg;

  localparam int unsigned DEFAULT_CAPACITY = 16;
  localparam int unsigned KEY_W            = 32;
  localparam int unsigned COUNT_W          = 5;

  localparam logic [1:0] ACT_PUSH  = 2'd0;
  localparam logic [1:0] ACT_POP   = 2'd1;
  localparam logic [1:0] ACT_FLUSH = 2'd2;

  localparam logic signed [KEY_W-1:0] POP_EMPTY_VALUE = '1;

  // Broadcast operation to every cell of the chain.
  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } cell_ctrl_t;

endpackage

### hw/rtl/smpq_if.sv
// Valid/ready channel interfaces for the sorted minimum priority queue.
// One interface for commands, one for results. No dependencies.
interface smpq_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [31:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface smpq_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] popped_value;
  logic               was_empty;
  logic               overflow;
  logic [4:0]         entry_count;

  modport source (output valid, output popped_value, output was_empty,
                  output overflow, output entry_count, input ready);
  modport sink   (input valid, input popped_value, input was_empty,
                  input overflow, input entry_count, output ready);
endinterface

### hw/rtl/sorted_min_priority_queue.sv
// Top level of the sorted minimum priority queue: a chain of compare/shift cells.
// Depends on smpq_pkg, smpq_if (smpq_in_if, smpq_out_if) and smpq_cell.
//
// Usage: each command transaction on in_i carries an action (push, pop or
// flush) and a value that only a push uses. Every command transaction yields
// exactly one result transaction on out_o, in order. A result carries the
// popped value (the smallest stored value on a pop, -1 on a pop of an empty
// queue, 0 otherwise), an empty flag, an overflow flag for a push onto a full
// queue, and the entry count after the command.
// The result is registered: it sits in the output register the cycle after
// the command is accepted. Throughput is one command per cycle while the
// receiver takes results, set by the cell chain, where every cell compares
// its key with the broadcast value and loads or shifts in that same cycle.
// When the receiver stalls, the result is held in the output register and
// in_i.ready drops until that result is taken; a new command is accepted in
// the same cycle the waiting result leaves.
// Reset clears every cell's valid bit, the entry count and the output valid;
// the stored keys themselves are not reset and need no clearing pass.
module sorted_min_priority_queue #(
  parameter int unsigned CAPACITY = smpq_pkg::DEFAULT_CAPACITY
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  smpq_in_if.sink    in_i,
  smpq_out_if.source out_o
);
  import smpq_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // Cell chain wiring.
  logic [CAPACITY-1:0]     valid_w;
  logic [CAPACITY-1:0]     lt_w;
  logic signed [KEY_W-1:0] entry_w [CAPACITY];
  cell_ctrl_t              ctrl;

  logic       accept;
  logic       is_push, is_pop, is_flush;
  logic       full, empty;

  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W+4:0]   count_ext;

  // Output register.
  logic                    out_valid_q;
  logic signed [KEY_W-1:0] popped_q, popped_d;
  logic                    was_empty_q, was_empty_d;
  logic                    overflow_q, overflow_d;
  logic [COUNT_W-1:0]      entry_count_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign is_push  = (in_i.action == ACT_PUSH);
  assign is_pop   = (in_i.action == ACT_POP);
  assign is_flush = (in_i.action == ACT_FLUSH);

  // Valid bits form a prefix, so the end cells tell full and empty.
  assign full  = valid_w[CAPACITY-1];
  assign empty = !valid_w[0];

  assign ctrl.push  = accept && is_push && !full;
  assign ctrl.pop   = accept && is_pop && !empty;
  assign ctrl.flush = accept && is_flush;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                    prev_lt, prev_valid, next_valid;
    logic signed [KEY_W-1:0] prev_entry, next_entry;

    if (i == 0) begin : g_head
      // The head cell always takes the new key unless it holds a smaller one.
      assign prev_lt    = 1'b1;
      assign prev_valid = 1'b1;
      assign prev_entry = '0;
    end else begin : g_body
      assign prev_lt    = lt_w[i-1];
      assign prev_valid = valid_w[i-1];
      assign prev_entry = entry_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_entry = '0;
    end else begin : g_mid
      assign next_valid = valid_w[i+1];
      assign next_entry = entry_w[i+1];
    end

    smpq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .key_i        (in_i.value),
      .prev_lt_i    (prev_lt),
      .prev_valid_i (prev_valid),
      .prev_entry_i (prev_entry),
      .next_valid_i (next_valid),
      .next_entry_i (next_entry),
      .lt_o         (lt_w[i]),
      .valid_o      (valid_w[i]),
      .entry_o      (entry_w[i])
    );
  end

  // Entry count after the command and the result fields.
  always_comb begin
    count_d     = count_q;
    popped_d    = '0;
    was_empty_d = 1'b0;
    overflow_d  = 1'b0;
    priority if (ctrl.flush) begin
      count_d = '0;
    end else if (ctrl.push) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctrl.pop) begin
      count_d  = count_q - CNT_W'(1);
      popped_d = entry_w[0];
    end else if (accept && is_pop) begin
      popped_d    = POP_EMPTY_VALUE;
      was_empty_d = 1'b1;
    end else if (accept && is_push) begin
      overflow_d = 1'b1;
    end
  end

  // The reported count is the stored count taken modulo 32.
  assign count_ext = {5'd0, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      popped_q      <= popped_d;
      was_empty_q   <= was_empty_d;
      overflow_q    <= overflow_d;
      entry_count_q <= count_ext[COUNT_W-1:0];
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.popped_value = popped_q;
  assign out_o.was_empty    = was_empty_q;
  assign out_o.overflow     = overflow_q;
  assign out_o.entry_count  = entry_count_q;

  // The occupied cells always form an unbroken run from the head.
  a_valid_prefix : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_w & ~{valid_w[CAPACITY-2:0], 1'b1}) == '0)
    else $error("valid cells are not a contiguous prefix");

  // The count register tracks the number of occupied cells.
  a_count_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_w) == 32'(count_q))
    else $error("entry count disagrees with occupied cells");

  // A push that is not dropped grows the queue by exactly one entry.
  a_push_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.push |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("push did not add one entry");

  // The two head cells stay in ascending order.
  a_head_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_w[1] |-> entry_w[0] <= entry_w[1])
    else $error("head entries out of order");

  // Every accepted command puts a result in the output register.
  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted command produced no result");

endmodule

### hw/rtl/smpq_cell.sv
// One storage cell of the sorted queue chain: a key and its valid bit.
// Depends on smpq_pkg.
module smpq_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  smpq_pkg::cell_ctrl_t                ctrl_i,
  input  logic signed [smpq_pkg::KEY_W-1:0]   key_i,
  input  logic                                prev_lt_i,
  input  logic                                prev_valid_i,
  input  logic signed [smpq_pkg::KEY_W-1:0]   prev_entry_i,
  input  logic                                next_valid_i,
  input  logic signed [smpq_pkg::KEY_W-1:0]   next_entry_i,
  output logic                                lt_o,
  output logic                                valid_o,
  output logic signed [smpq_pkg::KEY_W-1:0]   entry_o
);
  import smpq_pkg::*;

  logic                    valid_q, valid_d;
  logic signed [KEY_W-1:0] entry_q, entry_d;

  // Entries below the new key stay put; equal ones move behind it.
  assign lt_o = valid_q && (entry_q < key_i);

  always_comb begin
    entry_d = entry_q;
    valid_d = valid_q;
    priority if (ctrl_i.flush) begin
      valid_d = 1'b0;
    end else if (ctrl_i.pop) begin
      entry_d = next_entry_i;
      valid_d = next_valid_i;
    end else if (ctrl_i.push && !lt_o) begin
      entry_d = prev_lt_i ? key_i : prev_entry_i;
      valid_d = valid_q | prev_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign valid_o = valid_q;
  assign entry_o = entry_q;

endmodule
